// File: rtl/bpb_pkg.sv
// package for the branch predictor block
// holds sizes, mode codes, and the item and result types; no dependencies
package bpb_pkg;
    localparam int Entries = 64;
    localparam int KeyBits = 32;
    localparam int PcBits = 32;
    localparam int IdxBits = $clog2(Entries);
    localparam int CntBits = $clog2(Entries + 1);
    localparam int QDepth = 2;

    typedef enum logic [1:0] {
        MODE_BTB    = 2'd0,
        MODE_TWOBIT = 2'd1,
        MODE_STATIC = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    localparam logic ACT_PREDICT = 1'b0;
    localparam logic ACT_RESOLVE = 1'b1;

    typedef struct packed {
        logic              action;
        logic [KeyBits-1:0] branch_key;
        logic              resolved_taken;
        logic [PcBits-1:0] target_pc;
    } t_req;

    typedef struct packed {
        logic              predict_taken;
        logic [31:0]       predicted_pc;
        logic              hit;
        logic              table_full;
    } t_rsp;
endpackage

// File: rtl/bpb_if.sv
// valid/ready channel carrying one payload of a given type
// depends on bpb_pkg for the payload types
interface bpb_req_if;
    import bpb_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bpb_rsp_if;
    import bpb_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/bpb_front.sv
// front end: accepts requests and queues them for the back end
// depends on bpb_pkg and bpb_if
module bpb_front
    import bpb_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    bpb_req_if.sink      i_req,
    input  logic         i_pop,
    output logic         o_avail,
    output t_req         o_head
);
    t_req                r_q [QDepth];
    logic [$clog2(QDepth+1)-1:0] r_cnt;
    logic [$clog2(QDepth)-1:0]   r_rd, r_wr;
    logic push, pop;

    assign i_req.ready = (r_cnt != QDepth[$clog2(QDepth+1)-1:0]);
    assign push = i_req.valid && i_req.ready;
    assign pop = i_pop && (r_cnt != '0);
    assign o_avail = (r_cnt != '0);
    assign o_head = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd <= '0;
            r_wr <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + {{($clog2(QDepth+1)-1){1'b0}}, push}
                           - {{($clog2(QDepth+1)-1){1'b0}}, pop};
        end
        if (push) r_q[r_wr] <= i_req.data;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QDepth) else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !pop) else $error("pop of empty queue");
endmodule

// File: rtl/bpb_back.sv
// back end: in table mode searches the table one entry per cycle; updates state
// depends on bpb_pkg and bpb_if
module bpb_back
    import bpb_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [1:0]   i_mode,
    input  logic         i_avail,
    input  t_req         i_head,
    output logic         o_pop,
    bpb_rsp_if.source    o_rsp
);
    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} t_state;

    logic [KeyBits-1:0] r_keys [Entries];
    logic [PcBits-1:0]  r_tgts [Entries];
    logic               r_tkn  [Entries];

    t_state             r_state;
    logic [CntBits-1:0] r_count;
    logic [CntBits-1:0] r_idx;
    logic [1:0]         r_ctr;
    logic               r_valid;
    t_rsp               r_rsp;
    t_rsp               r_res;
    logic [KeyBits-1:0] r_key_rd;
    logic [PcBits-1:0]  r_tgt_rd;
    logic               r_tkn_rd;
    logic               r_rd_ok;

    logic [IdxBits-1:0] rd_addr;
    logic match;
    logic out_free;
    logic is_pred;
    logic fast_taken;
    logic [31:0] pc_ext;

    assign out_free = !r_valid || o_rsp.ready;
    assign o_rsp.valid = r_valid;
    assign o_rsp.data = r_rsp;
    assign o_pop = (r_state == S_DONE) && out_free;
    assign rd_addr = r_idx[IdxBits-1:0];
    assign match = r_rd_ok && (r_key_rd == i_head.branch_key);
    assign pc_ext = 32'(r_tgt_rd);
    assign is_pred = (i_head.action == ACT_PREDICT);
    assign fast_taken = is_pred && ((i_mode == MODE_TWOBIT && r_ctr[1]) || i_mode == MODE_STATIC);

    // registered read port; r_rd_ok marks that read data matches r_idx-1
    always_ff @(posedge i_clk) begin
        r_key_rd <= r_keys[rd_addr];
        r_tgt_rd <= r_tgts[rd_addr];
        r_tkn_rd <= r_tkn[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx <= '0;
            r_ctr <= 2'd0;
            r_valid <= 1'b0;
            r_rd_ok <= 1'b0;
        end else begin
            if (o_pop) r_valid <= 1'b1;
            else if (o_rsp.ready) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_rd_ok <= 1'b0;
                    if (i_avail) begin
                        if (i_mode == MODE_BTB) begin
                            r_idx <= '0;
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_DONE;
                            r_res <= '{predict_taken: fast_taken, predicted_pc: '0,
                                       hit: 1'b0, table_full: 1'b0};
                            if (i_mode == MODE_TWOBIT && !is_pred) begin
                                if (i_head.resolved_taken && r_ctr != 2'd3)
                                    r_ctr <= r_ctr + 2'd1;
                                else if (!i_head.resolved_taken && r_ctr != 2'd0)
                                    r_ctr <= r_ctr - 2'd1;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    // r_idx is the address now being read; data of r_idx-1 is on hand
                    if (match) begin
                        r_res <= '{predict_taken: is_pred && r_tkn_rd,
                                   predicted_pc: is_pred ? pc_ext : 32'd0,
                                   hit: 1'b1, table_full: 1'b0};
                        if (!is_pred) begin
                            r_tkn[rd_addr - 1'b1] <= i_head.resolved_taken;
                            r_tgts[rd_addr - 1'b1] <= i_head.target_pc;
                        end
                        r_state <= S_DONE;
                    end else if (r_idx == r_count || r_idx == Entries[CntBits-1:0]) begin
                        if (r_idx == r_count) begin
                            r_res <= '{predict_taken: 1'b0, predicted_pc: '0, hit: 1'b0,
                                       table_full: !is_pred &&
                                                   (r_count == Entries[CntBits-1:0])};
                            if (!is_pred && r_count != Entries[CntBits-1:0]) begin
                                r_keys[r_count[IdxBits-1:0]] <= i_head.branch_key;
                                r_tgts[r_count[IdxBits-1:0]] <= i_head.target_pc;
                                r_tkn[r_count[IdxBits-1:0]] <= i_head.resolved_taken;
                                r_count <= r_count + 1'b1;
                            end
                            r_state <= S_DONE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                            r_rd_ok <= 1'b1;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_rd_ok <= 1'b1;
                    end
                end
                S_DONE: begin
                    r_rd_ok <= 1'b0;
                    if (out_free) begin
                        r_rsp <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Entries) else $error("entry count past capacity");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid) else $error("pop without response");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_rsp.ready) |=> $stable(r_rsp)) else $error("response changed");
endmodule

// File: rtl/branch_predictor_btb_two_bit.sv
// branch predictor with target buffer, 2-bit counter, static and none modes
// non-table modes answer without a table search; table mode scans the stored
// entries in order; one item in flight, the queue absorbs the next requests
// in table mode, throughput is set by the sequential scan over the one memory read port
// synchronous active-low reset clears mode, counter, entry count and queues
module branch_predictor_btb_two_bit
    import bpb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    bpb_req_if.sink    i_req,
    bpb_rsp_if.source  o_rsp
);
    logic [1:0] r_mode;
    logic       avail, pop;
    t_req       head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mode <= MODE_BTB;
        else if (i_cfg_we) r_mode <= i_cfg_wdata;
    end

    bpb_front u_front (
        .i_clk, .i_rst_n, .i_req, .i_pop(pop), .o_avail(avail), .o_head(head)
    );

    bpb_back u_back (
        .i_clk, .i_rst_n, .i_mode(r_mode), .i_avail(avail), .i_head(head),
        .o_pop(pop), .o_rsp
    );
endmodule
